### rtl/core/rlbc_pkg.sv
`default_nettype none
package rlbc_pkg;

    localparam int DEF_COUNT_WIDTH = 16;
    localparam int PERIOD_W        = 16;
    localparam int BLANK_W         = 24;
    localparam int CFG_DATA_W      = 24;
    localparam int CFG_INDEX_W     = 3;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_PUSH = 2'd2;
    localparam logic [1:0] OP_POP  = 2'd3;

    localparam logic [2:0] MODE_OFF        = 3'd0;
    localparam logic [2:0] MODE_SLOW       = 3'd1;
    localparam logic [2:0] MODE_MED        = 3'd2;
    localparam logic [2:0] MODE_FAST       = 3'd3;
    localparam logic [2:0] MODE_MOSTLY_OFF = 3'd4;
    localparam logic [2:0] MODE_MOSTLY_ON  = 3'd5;
    localparam logic [2:0] MODE_ON         = 3'd6;

    localparam logic [CFG_INDEX_W-1:0] REG_FAST_PERIOD       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEDIUM_PERIOD     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_PERIOD       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MOSTLY_ON_PERIOD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MOSTLY_OFF_PERIOD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MOSTLY_ON_TIME    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MOSTLY_OFF_TIME   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_BLANK_TICKS       = 3'd7;

    localparam logic [2:0] COLOUR_GREEN = 3'b010;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] colour;
        logic [2:0] mode;
        logic       apply_now;
    } in_beat_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] fast_period;
        logic [PERIOD_W-1:0] medium_period;
        logic [PERIOD_W-1:0] slow_period;
        logic [PERIOD_W-1:0] mostly_on_period;
        logic [PERIOD_W-1:0] mostly_off_period;
        logic [PERIOD_W-1:0] mostly_on_time;
        logic [PERIOD_W-1:0] mostly_off_time;
        logic [BLANK_W-1:0]  blank_ticks;
        logic                blank_load;
    } cfg_t;

    typedef struct packed {
        logic [2:0] pins;
        logic       blanked;
    } result_t;

endpackage
`default_nettype wire

### rtl/core/rlbc_if.sv
`default_nettype none
interface rlbc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic       red;
    logic       green;
    logic       blue;
    logic [2:0] mode;
    logic       apply_now;

    modport source (output valid, output opcode, output red, output green, output blue,
                    output mode, output apply_now, input ready);
    modport sink (input valid, input opcode, input red, input green, input blue,
                  input mode, input apply_now, output ready);
endinterface

interface rlbc_out_if;
    logic valid;
    logic ready;
    logic red_pin;
    logic green_pin;
    logic blue_pin;
    logic blanked;

    modport source (output valid, output red_pin, output green_pin, output blue_pin,
                    output blanked, input ready);
    modport sink (input valid, input red_pin, input green_pin, input blue_pin,
                  input blanked, output ready);
endinterface
`default_nettype wire

### rtl/core/rgb_led_blink_controller_unit.sv
// Path: a beat accepted into the input register moves on to the result register
// when the core takes it; a stalled output holds it in the input register.
// Throughput: one beat per cycle unless the output stalls; an input register and a
// result register carry the two-stage pipeline, the state update runs in the second stage.
// Reset: rst_n is asynchronous, active low; it empties both stages, restores the
// register defaults and leaves the LED steady green.
`default_nettype none
module rgb_led_blink_controller_unit #(
    parameter int COUNT_WIDTH = rlbc_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    rlbc_in_if.sink                                 in_ch,
    rlbc_out_if.source                              out_ch,
    input  wire logic                               cfg_we,
    input  wire logic [rlbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rlbc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import rlbc_pkg::*;

    cfg_t     cfg;
    in_beat_t in_beat;
    in_beat_t beat;
    logic     beat_valid;
    logic     take;
    logic     in_ready;
    logic     out_valid;
    result_t  result;

    assign in_beat.opcode    = in_ch.opcode;
    assign in_beat.colour    = {in_ch.blue, in_ch.green, in_ch.red};
    assign in_beat.mode      = in_ch.mode;
    assign in_beat.apply_now = in_ch.apply_now;
    assign in_ch.ready       = in_ready;

    rlbc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rlbc_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_beat    (in_beat),
        .in_ready   (in_ready),
        .take       (take),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    rlbc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat       (beat),
        .take       (take),
        .cfg        (cfg),
        .out_ready  (out_ch.ready),
        .out_valid  (out_valid),
        .result     (result)
    );

    assign out_ch.valid     = out_valid;
    assign out_ch.red_pin   = result.pins[0];
    assign out_ch.green_pin = result.pins[1];
    assign out_ch.blue_pin  = result.pins[2];
    assign out_ch.blanked   = result.blanked;

endmodule
`default_nettype wire

### rtl/core/rlbc_cfg_regs.sv
`default_nettype none
module rlbc_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rlbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [rlbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output rlbc_pkg::cfg_t                          cfg
);
    import rlbc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next            = cfg_reg;
        cfg_next.blank_load = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FAST_PERIOD:       cfg_next.fast_period       = cfg_wdata[PERIOD_W-1:0];
                REG_MEDIUM_PERIOD:     cfg_next.medium_period     = cfg_wdata[PERIOD_W-1:0];
                REG_SLOW_PERIOD:       cfg_next.slow_period       = cfg_wdata[PERIOD_W-1:0];
                REG_MOSTLY_ON_PERIOD:  cfg_next.mostly_on_period  = cfg_wdata[PERIOD_W-1:0];
                REG_MOSTLY_OFF_PERIOD: cfg_next.mostly_off_period = cfg_wdata[PERIOD_W-1:0];
                REG_MOSTLY_ON_TIME:    cfg_next.mostly_on_time    = cfg_wdata[PERIOD_W-1:0];
                REG_MOSTLY_OFF_TIME:   cfg_next.mostly_off_time   = cfg_wdata[PERIOD_W-1:0];
                REG_BLANK_TICKS:
                begin
                    cfg_next.blank_ticks = cfg_wdata[BLANK_W-1:0];
                    cfg_next.blank_load  = 1'b1;
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_period       <= PERIOD_W'(8);
            cfg_reg.medium_period     <= PERIOD_W'(16);
            cfg_reg.slow_period       <= PERIOD_W'(32);
            cfg_reg.mostly_on_period  <= PERIOD_W'(32);
            cfg_reg.mostly_off_period <= PERIOD_W'(32);
            cfg_reg.mostly_on_time    <= PERIOD_W'(28);
            cfg_reg.mostly_off_time   <= PERIOD_W'(4);
            cfg_reg.blank_ticks       <= '0;
            cfg_reg.blank_load        <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

### rtl/core/rlbc_in_reg.sv
`default_nettype none
module rlbc_in_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire rlbc_pkg::in_beat_t in_beat,
    output logic                    in_ready,
    input  wire logic               take,
    output logic                    beat_valid,
    output rlbc_pkg::in_beat_t      beat
);
    import rlbc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t beat_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= in_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule
`default_nettype wire

### rtl/core/rlbc_core.sv
`default_nettype none
module rlbc_core #(
    parameter int COUNT_WIDTH = rlbc_pkg::DEF_COUNT_WIDTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               beat_valid,
    input  wire rlbc_pkg::in_beat_t beat,
    output logic                    take,
    input  wire rlbc_pkg::cfg_t     cfg,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output rlbc_pkg::result_t       result
);
    import rlbc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

    logic [2:0]             colour_reg, colour_next;
    logic [2:0]             mode_reg, mode_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [BLANK_W-1:0]     countdown_reg, countdown_next;
    logic [2:0]             saved_colour_reg, saved_colour_next;
    logic [2:0]             saved_mode_reg, saved_mode_next;
    logic [2:0]             pins_reg, pins_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                result_reg, result_next;

    logic                   fire;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_W-1:0]       count_cmp;
    logic                   lit;
    logic                   blank_on;
    logic [2:0]             load_colour;
    logic [2:0]             load_mode;
    logic                   do_load;

    assign take = !out_valid_reg || out_ready;
    assign fire = beat_valid && take;

    assign count_inc = COUNT_WIDTH'(count_reg + 1'b1);
    assign blank_on  = (cfg.blank_ticks != '0) && (mode_reg == MODE_ON);

    always_comb
    begin
        colour_next       = colour_reg;
        mode_next         = mode_reg;
        period_next       = period_reg;
        count_next        = count_reg;
        countdown_next    = countdown_reg;
        saved_colour_next = saved_colour_reg;
        saved_mode_next   = saved_mode_reg;
        pins_next         = pins_reg;
        count_cmp         = '0;
        lit               = 1'b0;
        load_colour       = beat.colour;
        load_mode         = beat.mode;
        do_load           = 1'b0;

        if (cfg.blank_load)
        begin
            countdown_next = cfg.blank_ticks;
        end

        if (fire)
        begin
            unique case (beat.opcode)
                OP_TICK:
                begin
                    count_next = (CMP_W'(count_inc) > CMP_W'(period_reg)) ? '0 : count_inc;
                    count_cmp  = CMP_W'(count_next);
                    case (mode_reg)
                        MODE_SLOW, MODE_MED, MODE_FAST:
                            lit = count_cmp < CMP_W'(period_reg >> 1);
                        MODE_MOSTLY_OFF: lit = count_cmp < CMP_W'(cfg.mostly_off_time);
                        MODE_MOSTLY_ON:  lit = count_cmp < CMP_W'(cfg.mostly_on_time);
                        MODE_ON:         lit = 1'b1;
                        default:         lit = 1'b0;
                    endcase
                    if (blank_on)
                    begin
                        if (countdown_reg != '0)
                        begin
                            countdown_next = countdown_reg - 1'b1;
                        end
                        else
                        begin
                            lit = 1'b0;
                        end
                    end
                    pins_next = lit ? colour_reg : 3'b000;
                end
                OP_SET:
                begin
                    do_load = 1'b1;
                end
                OP_PUSH:
                begin
                    saved_colour_next = colour_reg;
                    saved_mode_next   = mode_reg;
                end
                OP_POP:
                begin
                    do_load     = 1'b1;
                    load_colour = saved_colour_reg;
                    load_mode   = saved_mode_reg;
                end
                default: do_load = 1'b0;
            endcase

            if (do_load)
            begin
                case (load_mode)
                    MODE_FAST:       period_next = cfg.fast_period;
                    MODE_MED:        period_next = cfg.medium_period;
                    MODE_SLOW:       period_next = cfg.slow_period;
                    MODE_MOSTLY_ON:  period_next = cfg.mostly_on_period;
                    MODE_MOSTLY_OFF: period_next = cfg.mostly_off_period;
                    default:         period_next = period_reg;
                endcase
                colour_next    = load_colour;
                mode_next      = load_mode;
                countdown_next = cfg.blank_ticks;
                if ((beat.opcode == OP_SET) && beat.apply_now)
                begin
                    pins_next = load_colour;
                end
            end
        end

        result_next.pins    = pins_next;
        result_next.blanked = (cfg.blank_ticks != '0) && (mode_next == MODE_ON)
                              && (countdown_next == '0);
        out_valid_next      = take ? beat_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_reg       <= COLOUR_GREEN;
            mode_reg         <= MODE_ON;
            period_reg       <= '0;
            count_reg        <= '0;
            countdown_reg    <= '0;
            saved_colour_reg <= '0;
            saved_mode_reg   <= '0;
            pins_reg         <= COLOUR_GREEN;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            colour_reg       <= colour_next;
            mode_reg         <= mode_next;
            period_reg       <= period_next;
            count_reg        <= count_next;
            countdown_reg    <= countdown_next;
            saved_colour_reg <= saved_colour_next;
            saved_mode_reg   <= saved_mode_next;
            pins_reg         <= pins_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule
`default_nettype wire

### rtl/core/rlbc_checker.sv
`default_nettype none
module rlbc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic red_pin,
    input wire logic green_pin,
    input wire logic blue_pin,
    input wire logic blanked
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable(red_pin) && $stable(green_pin) && $stable(blue_pin) && $stable(blanked))
        else $error("stalled result beat changed");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("accepted beat gave no result two cycles later");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output free");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result beat present right after reset");

endmodule

bind rgb_led_blink_controller_unit rlbc_checker u_rlbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .red_pin   (out_ch.red_pin),
    .green_pin (out_ch.green_pin),
    .blue_pin  (out_ch.blue_pin),
    .blanked   (out_ch.blanked)
);
`default_nettype wire

### dv/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlbc_pkg::*;

    localparam int          CNT_W         = DEF_COUNT_WIDTH;
    localparam int          NUM_REGS      = 8;
    localparam int          CYCLE_LIMIT   = 300000;
    localparam int          RANDOM_PHASES = 7;
    localparam int          PHASE_ITEMS   = 120;
    localparam int          HOLD_CYCLES   = 64;
    localparam int          TAIL_CYCLES   = 6;
    localparam logic [2:0]  MODE_UNUSED   = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    rlbc_in_if  in_ch();
    rlbc_out_if out_ch();

    rgb_led_blink_controller_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // LED state as the testbench sees it
    logic [PERIOD_W-1:0] fast_per, med_per, slow_per, mon_per, moff_per;
    logic [PERIOD_W-1:0] mon_time, moff_time;
    logic [BLANK_W-1:0]  blank_cfg, countdown;
    logic [2:0]          colour_q, mode_q, saved_colour, saved_mode, pins_q;
    logic [PERIOD_W-1:0] period_q;
    logic [CNT_W-1:0]    count_q;

    result_t pin_expect_q[$];

    int  err_cnt;
    int  items_sent;
    int  results_seen;
    int  blank_seen;
    int  settings_written;
    int  cycle_cnt;
    int  op_seen[4];
    bit  no_gaps;
    bit  hold_req;

    task automatic report(string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic latch_colour(logic [2:0] c, logic [2:0] m);
        case (m)
            MODE_FAST:       period_q = fast_per;
            MODE_MED:        period_q = med_per;
            MODE_SLOW:       period_q = slow_per;
            MODE_MOSTLY_ON:  period_q = mon_per;
            MODE_MOSTLY_OFF: period_q = moff_per;
            default:         ;
        endcase
        colour_q  = c;
        mode_q    = m;
        countdown = blank_cfg;
    endtask

    task automatic led_predict(in_beat_t b);
        logic    lit;
        result_t r;
        case (b.opcode)
            OP_TICK:
            begin
                count_q = count_q + 1'b1;
                if (count_q > period_q)
                begin
                    count_q = '0;
                end
                case (mode_q)
                    MODE_SLOW, MODE_MED, MODE_FAST: lit = count_q < (period_q >> 1);
                    MODE_MOSTLY_OFF:                lit = count_q < moff_time;
                    MODE_MOSTLY_ON:                 lit = count_q < mon_time;
                    MODE_ON:                        lit = 1'b1;
                    default:                        lit = 1'b0;
                endcase
                if (blank_cfg != 0 && mode_q == MODE_ON)
                begin
                    if (countdown != 0)
                    begin
                        countdown = countdown - 1'b1;
                    end
                    else
                    begin
                        lit = 1'b0;
                    end
                end
                pins_q = lit ? colour_q : 3'b000;
            end
            OP_SET:
            begin
                latch_colour(b.colour, b.mode);
                if (b.apply_now)
                begin
                    pins_q = colour_q;
                end
            end
            OP_PUSH:
            begin
                saved_colour = colour_q;
                saved_mode   = mode_q;
            end
            default: latch_colour(saved_colour, saved_mode);
        endcase
        r.pins    = pins_q;
        r.blanked = blank_cfg != 0 && mode_q == MODE_ON && countdown == 0;
        pin_expect_q.push_back(r);
        op_seen[b.opcode]++;
    endtask

    function automatic int pick_gap();
        int r;
        if (no_gaps)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // predict each accepted beat
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        begin
            led_predict({in_ch.opcode, in_ch.blue, in_ch.green, in_ch.red,
                         in_ch.mode, in_ch.apply_now});
        end
    end

    task automatic check_bit(string name, logic got, logic want);
        if (got !== want)
        begin
            report($sformatf("%s expected %0b, got %0b", name, want, got));
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            results_seen++;
            if (pin_expect_q.size() == 0)
            begin
                report("result beat with nothing pending");
            end
            else
            begin
                want = pin_expect_q.pop_front();
                check_bit("red_pin",   out_ch.red_pin,   want.pins[0]);
                check_bit("green_pin", out_ch.green_pin, want.pins[1]);
                check_bit("blue_pin",  out_ch.blue_pin,  want.pins[2]);
                check_bit("blanked",   out_ch.blanked,   want.blanked);
                if (want.blanked)
                begin
                    blank_seen++;
                end
            end
        end
    end

    // result side: random stalls, plus one long hold on request
    initial
    begin
        int stall;
        int hold;
        stall        = 0;
        hold         = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold     = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                out_ch.ready <= 1'b0;
                hold--;
            end
            else if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else if (no_gaps || $urandom_range(0, 3) != 0)
            begin
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= 1'b0;
                stall = pick_gap();
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Timed out with %0d results pending", pin_expect_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_beat(logic [1:0] op, logic [2:0] c, logic [2:0] m, logic now);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= op;
        in_ch.red       <= c[0];
        in_ch.green     <= c[1];
        in_ch.blue      <= c[2];
        in_ch.mode      <= m;
        in_ch.apply_now <= now;
        do
        begin
            @(posedge clk);
        end
        while (in_ch.ready !== 1'b1);
        items_sent++;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_ticks(int n);
        repeat (n)
        begin
            send_beat(OP_TICK, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_noise();
        send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pin_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // leaves cfg_we high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_FAST_PERIOD:       fast_per  = data[PERIOD_W-1:0];
            REG_MEDIUM_PERIOD:     med_per   = data[PERIOD_W-1:0];
            REG_SLOW_PERIOD:       slow_per  = data[PERIOD_W-1:0];
            REG_MOSTLY_ON_PERIOD:  mon_per   = data[PERIOD_W-1:0];
            REG_MOSTLY_OFF_PERIOD: moff_per  = data[PERIOD_W-1:0];
            REG_MOSTLY_ON_TIME:    mon_time  = data[PERIOD_W-1:0];
            REG_MOSTLY_OFF_TIME:   moff_time = data[PERIOD_W-1:0];
            default:
            begin
                blank_cfg = data[BLANK_W-1:0];
                countdown = blank_cfg;
            end
        endcase
        settings_written++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_setting(int phase, int idx);
        logic [CFG_DATA_W-1:0] top;
        int                    r;
        top = (idx == REG_BLANK_TICKS) ? 24'hFF_FFFF : 24'h00_FFFF;
        r   = $urandom_range(0, 9);
        case (phase)
            0: return '0;
            1: return (idx == REG_MOSTLY_ON_TIME || idx == REG_MOSTLY_OFF_TIME) ? '0 : 24'd1;
            2: return top;
            default:
            begin
                if (idx == REG_BLANK_TICKS && r < 4)
                begin
                    return '0;
                end
                case (r)
                    0:       return '0;
                    1:       return top;
                    2:       return CFG_DATA_W'($urandom) & top;
                    default: return CFG_DATA_W'($urandom_range(1, 40));
                endcase
            end
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_beat(OP_TICK, 3'b000, MODE_OFF, 1'b0);
        send_beat(OP_PUSH, 3'b111, MODE_ON, 1'b1);
        send_beat(OP_POP, 3'b101, MODE_FAST, 1'b1);
        send_beat(OP_TICK, 3'b000, MODE_OFF, 1'b0);
    endtask

    task automatic test_each_mode();
        logic [2:0] modes [8];
        modes = '{MODE_OFF, MODE_SLOW, MODE_MED, MODE_FAST,
                  MODE_MOSTLY_OFF, MODE_MOSTLY_ON, MODE_ON, MODE_UNUSED};
        foreach (modes[i])
        begin
            send_beat(OP_SET, modes[i] ^ 3'b101, modes[i], 1'b1);
            send_beat(OP_TICK, 3'b000, MODE_OFF, 1'b0);
        end
    endtask

    task automatic test_blank_timeout();
        settle();
        write_reg(REG_BLANK_TICKS, 24'd2);
        cfg_we <= 1'b0;
        send_beat(OP_SET, 3'b111, MODE_ON, 1'b0);
        send_ticks(3);
        // reload with the LED already blanked
        settle();
        write_reg(REG_BLANK_TICKS, 24'd1);
        cfg_we <= 1'b0;
        send_ticks(2);
        settle();
        write_reg(REG_BLANK_TICKS, 24'd0);
        cfg_we <= 1'b0;
        send_ticks(1);
    endtask

    task automatic test_random_phases();
        int stop_at;
        int r;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            for (int i = 0; i < NUM_REGS; i++)
            begin
                write_reg(CFG_INDEX_W'(i), pick_setting(p, i));
            end
            cfg_we  <= 1'b0;
            no_gaps  = (p == 4);
            stop_at  = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at)
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    send_beat(OP_SET, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)));
                    send_ticks($urandom_range(4, 40));
                end
                else if (r < 82)
                begin
                    send_beat(OP_PUSH, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)));
                    send_beat(OP_SET, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)));
                    send_ticks($urandom_range(2, 20));
                    send_beat(OP_POP, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)));
                    send_ticks($urandom_range(2, 20));
                end
                else
                begin
                    repeat ($urandom_range(1, 5)) send_noise();
                end
            end
            no_gaps = 1'b0;
        end
    endtask

    task automatic test_output_backpressure();
        settle();
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        send_beat(OP_SET, 3'($urandom_range(1, 7)), MODE_FAST, 1'b1);
        send_ticks(20);
        repeat (9) send_noise();
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.opcode    = OP_TICK;
        in_ch.red       = 1'b0;
        in_ch.green     = 1'b0;
        in_ch.blue      = 1'b0;
        in_ch.mode      = MODE_OFF;
        in_ch.apply_now = 1'b0;
        no_gaps         = 1'b0;
        hold_req        = 1'b0;
        err_cnt         = 0;
        items_sent      = 0;
        results_seen    = 0;
        blank_seen      = 0;
        settings_written = 0;
        op_seen         = '{0, 0, 0, 0};

        fast_per     = 16'd8;
        med_per      = 16'd16;
        slow_per     = 16'd32;
        mon_per      = 16'd32;
        moff_per     = 16'd32;
        mon_time     = 16'd28;
        moff_time    = 16'd4;
        blank_cfg    = '0;
        colour_q     = COLOUR_GREEN;
        mode_q       = MODE_ON;
        period_q     = '0;
        count_q      = '0;
        countdown    = '0;
        saved_colour = '0;
        saved_mode   = MODE_OFF;
        pins_q       = COLOUR_GREEN;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_each_mode();
        test_blank_timeout();
        test_random_phases();
        test_output_backpressure();

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pin_expect_q.size() != 0)
        begin
            report($sformatf("%0d results never arrived", pin_expect_q.size()));
        end

        $display("Sent %0d beats: %0d tick, %0d set colour, %0d push, %0d pop; %0d register writes",
                 items_sent, op_seen[OP_TICK], op_seen[OP_SET], op_seen[OP_PUSH],
                 op_seen[OP_POP], settings_written);
        $display("Checked %0d results (%0d blanked) in %0d cycles, %0d mismatches",
                 results_seen, blank_seen, cycle_cnt, err_cnt);
        if (err_cnt == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
rtl/core/rlbc_pkg.sv
rtl/core/rlbc_if.sv
rtl/core/rlbc_cfg_regs.sv
rtl/core/rlbc_in_reg.sv
rtl/core/rlbc_core.sv
rtl/core/rgb_led_blink_controller_unit.sv
rtl/core/rlbc_checker.sv
dv/tb.sv
